/* rtl/pmc_pkg.sv */
`timescale 1ns / 1ps

package pmc_pkg;

    localparam int HEX_DIGIT_COUNT = 8;

    localparam int POS_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int PC_W       = 32;
    localparam int TEXT_MAX   = 28;
    localparam int OUT_DATA_W = 40;

    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    localparam int HEAD_LEN   = 27;
    localparam int TAIL_LEN   = 9;
    localparam int HEX_END    = HEAD_LEN + HEX_DIGIT_COUNT;
    localparam int TAIL_END   = HEX_END + TAIL_LEN;
    localparam int DIGIT_POS  = TAIL_END;
    localparam int END_POS    = TAIL_END + 1;

    localparam int ASSERT_LEN   = 6;
    localparam int ABORT_LEN    = 5;
    localparam int SMASHING_LEN = 14;
    localparam int SMASH_LEN    = 11;

    localparam logic [8*TEXT_MAX-1:0] TXT_ASSERT   = "assert";
    localparam logic [8*TEXT_MAX-1:0] TXT_ABORT    = "abort";
    localparam logic [8*TEXT_MAX-1:0] TXT_SMASHING = "stack smashing";
    localparam logic [8*TEXT_MAX-1:0] TXT_SMASH    = "stack-smash";
    localparam logic [8*TEXT_MAX-1:0] TXT_HEAD     = "abort() was called at PC 0x";
    localparam logic [8*TEXT_MAX-1:0] TXT_TAIL     = " on core ";

    typedef enum logic [1:0] {
        REASON_OTHER  = 2'd0,
        REASON_ASSERT = 2'd1,
        REASON_ABORT  = 2'd2,
        REASON_SMASH  = 2'd3
    } reason_t;

    typedef struct packed {
        reason_t          reason_code;
        logic             caller_pc_valid;
        logic [PC_W-1:0]  caller_pc;
        logic             clear_assert_record;
    } pmc_result_t;

    // character idx of a right-aligned string of length len
    function automatic logic [CHAR_W-1:0] text_char(input logic [8*TEXT_MAX-1:0] txt,
                                                   input int len,
                                                   input logic [POS_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        for (int i = 0; i < TEXT_MAX; i++) begin
            if (i < len && int'(idx) == i) begin
                ch = txt[8*(len-1-i) +: 8];
            end
        end
        return ch;
    endfunction

endpackage

/* rtl/pmc_parse_core.sv */
`timescale 1ns / 1ps

module pmc_parse_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  logic [pmc_pkg::CHAR_W-1:0]  msg_char,
    input  logic                        starts_message,
    output logic                        res_valid,
    output pmc_pkg::pmc_result_t        result
);
    import pmc_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [3:0]       flags_reg, flags_next;
    logic             alive_reg, alive_next;
    logic [PC_W-1:0]  acc_reg,   acc_next;

    logic [POS_W-1:0]  pos;
    logic [3:0]        flags;
    logic              alive;
    logic [PC_W-1:0]   acc;
    logic [CHAR_W-1:0] lc;
    logic [CHAR_W-1:0] ch_off;
    logic [POS_W-1:0]  tail_idx;
    logic [3:0]        flags_upd;
    logic              ok;
    logic              is_hex;
    logic [3:0]        hex_val;
    logic [PC_W-1:0]   acc_upd;
    logic              is_end;
    reason_t           reason;

    always_comb begin
        pos   = starts_message ? '0 : pos_reg;
        flags = starts_message ? 4'hF : flags_reg;
        alive = starts_message ? 1'b1 : alive_reg;
        acc   = starts_message ? '0 : acc_reg;

        lc = (msg_char >= "A" && msg_char <= "Z") ? msg_char + 8'd32 : msg_char;

        flags_upd = flags;
        if (pos < POS_W'(ASSERT_LEN) && lc != text_char(TXT_ASSERT, ASSERT_LEN, pos))
            flags_upd[0] = 1'b0;
        if (pos < POS_W'(ABORT_LEN) && lc != text_char(TXT_ABORT, ABORT_LEN, pos))
            flags_upd[1] = 1'b0;
        if (pos < POS_W'(SMASHING_LEN) && lc != text_char(TXT_SMASHING, SMASHING_LEN, pos))
            flags_upd[2] = 1'b0;
        if (pos < POS_W'(SMASH_LEN) && lc != text_char(TXT_SMASH, SMASH_LEN, pos))
            flags_upd[3] = 1'b0;

        is_hex  = 1'b1;
        ch_off  = msg_char - 8'h30;
        if (msg_char >= "0" && msg_char <= "9") begin
            ch_off = msg_char - 8'h30;
        end else if (msg_char >= "a" && msg_char <= "f") begin
            ch_off = msg_char - 8'h57;
        end else if (msg_char >= "A" && msg_char <= "F") begin
            ch_off = msg_char - 8'h37;
        end else begin
            is_hex = 1'b0;
        end
        hex_val  = ch_off[3:0];
        tail_idx = pos - POS_W'(HEX_END);

        acc_upd = acc;
        if (pos < POS_W'(HEAD_LEN)) begin
            ok = (msg_char == text_char(TXT_HEAD, HEAD_LEN, pos));
        end else if (pos < POS_W'(HEX_END)) begin
            ok = is_hex;
            if (alive && is_hex)
                acc_upd = {acc[PC_W-5:0], hex_val};
        end else if (pos < POS_W'(TAIL_END)) begin
            ok = (msg_char == text_char(TXT_TAIL, TAIL_LEN, tail_idx));
        end else if (pos == POS_W'(DIGIT_POS)) begin
            ok = (msg_char >= "0" && msg_char <= "9");
        end else if (pos == POS_W'(END_POS)) begin
            ok = (msg_char == 8'h00);
        end else begin
            ok = 1'b0;
        end

        is_end = (msg_char == 8'h00);

        if (flags_upd[0])
            reason = REASON_ASSERT;
        else if (flags_upd[1])
            reason = REASON_ABORT;
        else if (flags_upd[3:2] != 2'b00)
            reason = REASON_SMASH;
        else
            reason = REASON_OTHER;

        result.reason_code         = reason;
        result.caller_pc_valid     = alive && ok;
        result.caller_pc           = (alive && ok) ? acc_upd : '0;
        result.clear_assert_record = (reason != REASON_ASSERT);
        res_valid                  = fire && is_end;

        if (is_end) begin
            pos_next   = '0;
            flags_next = 4'hF;
            alive_next = 1'b1;
            acc_next   = '0;
        end else begin
            pos_next   = (pos < POS_MAX) ? pos + 1'b1 : pos;
            flags_next = flags_upd;
            alive_next = alive && ok;
            acc_next   = acc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= 4'hF;
            alive_reg <= 1'b1;
            acc_reg   <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            alive_reg <= alive_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

/* rtl/panic_message_classifier.sv */
`timescale 1ns / 1ps

// Crash message classifier.
// Input: one message byte per transaction on s_tdata, s_tuser high on the
// first byte of a message; a zero byte terminates the message. Only the
// terminator produces an output transaction on m_tdata carrying the reason
// code, the parsed abort caller PC with its valid flag, and the flag that
// clears the assert record.
// Each byte lands in an input register and is parsed from there against the
// per-message state by combinational compare logic; m_tvalid rises when the
// terminator's result is loaded into the output register. One byte per cycle
// is sustained, back-to-back messages included, except while a terminator waits.
// When m_tready is low with a result pending, non-terminator bytes keep
// flowing; a terminator waits in the input register until the output
// register frees, and s_tready drops meanwhile.
// Reset (aresetn low, synchronous) empties both registers and rearms the
// parser as if a new message starts.
module panic_message_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] msg_char
    input  logic                            s_tuser,   // [0] starts_message
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] reason_code, [2] caller_pc_valid, [34:3] caller_pc,
    // [35] clear_assert_record, [39:36] zero
    output logic [pmc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import pmc_pkg::*;

    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    pmc_result_t        out_data_reg;

    logic               out_free;
    logic               fire;
    logic               res_valid;
    pmc_result_t        result;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (in_char_reg != 8'h00 || out_free);
    assign s_tready = !in_valid_reg || fire;

    pmc_parse_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .msg_char       (in_char_reg),
        .starts_message (in_start_reg),
        .res_valid      (res_valid),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (res_valid)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_data_reg.clear_assert_record,
                       out_data_reg.caller_pc,
                       out_data_reg.caller_pc_valid,
                       out_data_reg.reason_code};

endmodule

/* tb/sv/panic_message_classifier_tb.sv */
`timescale 1ns / 1ps

module panic_message_classifier_tb;
    import pmc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 355;
    localparam int DRAIN_CYCLES = 20;

    localparam int PFX_ASSERT   = 0;
    localparam int PFX_ABORT    = 1;
    localparam int PFX_SMASHING = 2;
    localparam int PFX_SMASH    = 3;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_BYTE,
        FLAW_CUT,
        FLAW_EXTRA
    } flaw_t;

    typedef logic [CHAR_W-1:0] byte_q_t[$];

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              mark;
    } msg_byte_t;

    typedef struct {
        reason_t          reason;
        logic             pc_valid;
        logic [PC_W-1:0]  pc;
        logic             clear_rec;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    panic_message_classifier uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    string prefix_text [4] = '{"assert", "abort", "stack smashing", "stack-smash"};
    string head_text = "abort() was called at PC 0x";
    string tail_text = " on core ";

    int idle_by_phase  [4] = '{0, 71, 0, 26};
    int stall_by_phase [4] = '{0, 0, 71, 26};

    msg_byte_t pending_bytes[$];
    verdict_t  expected_verdicts[$];

    int   queued_bytes = 0;
    int   errors = 0;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic in_taken = 1'b0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    int   hold_count = 0;

    // parser state of the predictor
    logic [POS_W-1:0] msg_pos;
    logic [3:0]       prefix_live;
    logic             grammar_live;
    logic [PC_W-1:0]  pc_shift;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void rearm_parser();
        msg_pos      = '0;
        prefix_live  = 4'hF;
        grammar_live = 1'b1;
        pc_shift     = '0;
    endfunction

    function automatic void classify_byte(input logic [CHAR_W-1:0] ch, input logic mark);
        logic [CHAR_W-1:0] low_ch;
        logic [3:0]        nib;
        logic              ok;
        int                p;
        verdict_t          v;
        if (mark) begin
            rearm_parser();
        end
        p = msg_pos;
        low_ch = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
        for (int k = 0; k < 4; k++) begin
            if (p < prefix_text[k].len() && low_ch != prefix_text[k][p]) begin
                prefix_live[k] = 1'b0;
            end
        end
        if (grammar_live) begin
            ok = 1'b1;
            nib = '0;
            if (p < HEAD_LEN) begin
                ok = (ch == head_text[p]);
            end else if (p < HEX_END) begin
                if (ch >= "0" && ch <= "9") begin
                    nib = 4'(ch - "0");
                end else if (ch >= "a" && ch <= "f") begin
                    nib = 4'(ch - "a" + 10);
                end else if (ch >= "A" && ch <= "F") begin
                    nib = 4'(ch - "A" + 10);
                end else begin
                    ok = 1'b0;
                end
                if (ok) begin
                    pc_shift = {pc_shift[PC_W-5:0], nib};
                end
            end else if (p < TAIL_END) begin
                ok = (ch == tail_text[p - HEX_END]);
            end else if (p == DIGIT_POS) begin
                ok = (ch >= "0" && ch <= "9");
            end else if (p == END_POS) begin
                ok = (ch == 8'd0);
            end else begin
                ok = 1'b0;
            end
            if (!ok) begin
                grammar_live = 1'b0;
            end
        end
        if (ch == 8'd0) begin
            if (prefix_live[PFX_ASSERT]) begin
                v.reason = REASON_ASSERT;
            end else if (prefix_live[PFX_ABORT]) begin
                v.reason = REASON_ABORT;
            end else if (prefix_live[PFX_SMASHING] || prefix_live[PFX_SMASH]) begin
                v.reason = REASON_SMASH;
            end else begin
                v.reason = REASON_OTHER;
            end
            v.pc_valid  = grammar_live;
            v.pc        = grammar_live ? pc_shift : '0;
            v.clear_rec = (v.reason != REASON_ASSERT);
            expected_verdicts.push_back(v);
            rearm_parser();
        end else if (msg_pos != POS_MAX) begin
            msg_pos = msg_pos + 1'b1;
        end
    endfunction

    function automatic void check_verdict(input logic [OUT_DATA_W-1:0] word);
        verdict_t want;
        if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, word);
            errors++;
        end else begin
            want = expected_verdicts.pop_front();
            if (word[1:0] !== want.reason) begin
                $display("%0t: reason_code expected %0d actual %0d",
                         $time, want.reason, word[1:0]);
                errors++;
            end
            if (word[2] !== want.pc_valid) begin
                $display("%0t: caller_pc_valid expected %0b actual %0b",
                         $time, want.pc_valid, word[2]);
                errors++;
            end
            if (word[34:3] !== want.pc) begin
                $display("%0t: caller_pc expected %h actual %h", $time, want.pc, word[34:3]);
                errors++;
            end
            if (word[35] !== want.clear_rec) begin
                $display("%0t: clear_assert_record expected %0b actual %0b",
                         $time, want.clear_rec, word[35]);
                errors++;
            end
            if (word[OUT_DATA_W-1:36] !== '0) begin
                $display("%0t: pad bits expected 0 actual %h", $time, word[OUT_DATA_W-1:36]);
                errors++;
            end
        end
    endfunction

    // input driver
    always @(negedge aclk) begin : feed_bytes
        msg_byte_t nb;
        if (!s_tvalid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nb = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nb.ch;
                s_tuser  <= nb.mark;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off
    always @(negedge aclk) begin
        if (hold_armed && !hold_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_done = 1'b1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("panic_message_classifier regression: fail");
            $finish;
        end else if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_verdict(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                classify_byte(s_tdata, s_tuser);
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    function automatic byte_q_t string_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic void push_text(input byte_q_t text, input logic mark,
                                      input bit terminate, input bit stray_marks);
        logic m;
        if (terminate) begin
            text.push_back(8'd0);
        end
        foreach (text[i]) begin
            m = (i == 0) ? mark : (stray_marks && $urandom_range(9) == 0);
            pending_bytes.push_back('{text[i], m});
        end
        queued_bytes += text.size();
    endfunction

    function automatic byte_q_t pc_message_bytes(input logic [PC_W-1:0] pc,
                                                 input int core_digit);
        byte_q_t q;
        logic [3:0] nib;
        q = string_bytes(head_text);
        for (int i = HEX_DIGIT_COUNT - 1; i >= 0; i--) begin
            nib = (i < 8) ? pc[4*i +: 4] : 4'($urandom_range(15));
            if (nib < 10) begin
                q.push_back(8'("0" + nib));
            end else begin
                q.push_back(8'(($urandom_range(1) ? "a" : "A") + nib - 10));
            end
        end
        for (int i = 0; i < tail_text.len(); i++) begin
            q.push_back(tail_text[i]);
        end
        q.push_back(8'("0" + core_digit));
        return q;
    endfunction

    function automatic void apply_flaw(ref byte_q_t q, input flaw_t flaw);
        int n;
        case (flaw)
            FLAW_BAD_BYTE: begin
                q[$urandom_range(q.size() - 1)] = 8'($urandom_range(1, 255));
            end
            FLAW_CUT: begin
                n = $urandom_range(q.size() - 1);
                while (q.size() > n) begin
                    void'(q.pop_back());
                end
            end
            FLAW_EXTRA: begin
                q.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_random_message();
        byte_q_t q;
        logic [PC_W-1:0] pc;
        logic mark;
        int pick;
        int k;
        pick = $urandom_range(99);
        mark = ($urandom_range(7) != 0);
        if (pick < 30) begin
            case ($urandom_range(7))
                0:       pc = '0;
                1:       pc = '1;
                default: pc = $urandom;
            endcase
            q = pc_message_bytes(pc, $urandom_range(9));
            if ($urandom_range(9) < 4) begin
                apply_flaw(q, flaw_t'($urandom_range(FLAW_EXTRA, FLAW_BAD_BYTE)));
            end
            push_text(q, mark, 1'b1, 1'b0);
        end else if (pick < 60) begin
            k = $urandom_range(3);
            q = string_bytes(prefix_text[k]);
            foreach (q[i]) begin
                if (q[i] >= "a" && q[i] <= "z" && $urandom_range(1)) begin
                    q[i] = q[i] - 8'd32;
                end
            end
            if ($urandom_range(3) == 0) begin
                apply_flaw(q, flaw_t'($urandom_range(FLAW_EXTRA, FLAW_BAD_BYTE)));
            end
            repeat ($urandom_range(8)) begin
                q.push_back(8'($urandom_range(32, 126)));
            end
            push_text(q, mark, 1'b1, 1'b0);
        end else if (pick < 85) begin
            repeat ($urandom_range(12)) begin
                q.push_back(8'($urandom_range(1, 255)));
            end
            push_text(q, mark, ($urandom_range(9) != 0), 1'b1);
        end else if (pick < 95) begin
            q = string_bytes(prefix_text[$urandom_range(3)]);
            apply_flaw(q, FLAW_CUT);
            push_text(q, mark, 1'b1, 1'b0);
        end else begin
            if ($urandom_range(1)) begin
                q = string_bytes(prefix_text[$urandom_range(3)]);
            end else begin
                q = pc_message_bytes($urandom, $urandom_range(9));
            end
            repeat ($urandom_range(10, 40)) begin
                q.push_back(8'($urandom_range(1, 255)));
            end
            push_text(q, mark, 1'b1, 1'b0);
        end
    endfunction

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        byte_q_t q;
        int target;
        rearm_parser();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_text(string_bytes(""), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("assert"), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("AsSeRt failed"), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("abort"), 1'b0, 1'b1, 1'b0);
        push_text(string_bytes("stack smashing detected"), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("Stack-Smash"), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("stack smash"), 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("asser"), 1'b1, 1'b1, 1'b0);
        push_text(pc_message_bytes(32'hDEADBEEF, 7), 1'b1, 1'b1, 1'b0);
        push_text(pc_message_bytes(32'hFFFFFFFF, 9), 1'b1, 1'b1, 1'b0);
        q = pc_message_bytes(32'h0, 0);
        q.push_back("9");
        push_text(q, 1'b1, 1'b1, 1'b0);
        q = pc_message_bytes(32'h12345678, 3);
        void'(q.pop_back());
        push_text(q, 1'b1, 1'b1, 1'b0);
        q = pc_message_bytes(32'h4008ABCD, 1);
        q[0] = "A";
        push_text(q, 1'b1, 1'b1, 1'b0);
        push_text(string_bytes("abo"), 1'b1, 1'b0, 1'b0);
        push_text(string_bytes("assert"), 1'b1, 1'b1, 1'b0);
        push_text('{8'hFF, 8'h80, 8'h01, 8'h7F}, 1'b1, 1'b1, 1'b0);
        q = string_bytes("assert");
        repeat (70) begin
            q.push_back(8'($urandom_range(1, 255)));
        end
        push_text(q, 1'b1, 1'b1, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_by_phase[ph];
            recv_stall_pct  = stall_by_phase[ph];
            if (ph == 0) begin
                hold_armed = 1'b1;
            end
            target = queued_bytes + PHASE_BYTES;
            while (queued_bytes < target) begin
                queue_random_message();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("panic_message_classifier regression: pass");
        end else begin
            $display("panic_message_classifier regression: fail");
        end
        $finish;
    end

endmodule
